// ----- design/madt_pkg.sv -----
// shared constants, types and tables of the interrupt controller table parser
package madt_pkg;

  localparam int unsigned DEF_OFFSET_BITS = 16;
  localparam int unsigned DEF_COUNT_BITS  = 8;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_OUT_W  = 8;
  localparam int unsigned RES_BITS   = 3 + 2 * CNT_OUT_W + 3 * ADDR_W;
  localparam int unsigned RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

  // table layout
  localparam logic [LEN_W-1:0] HDR_FIXED_END = 32'd8;
  localparam logic [LEN_W-1:0] LOCAL_ADDR_OFS = 32'd36;
  localparam logic [LEN_W-1:0] ENTRY_START_OFS = 32'd44;

  // entry kinds
  localparam logic [BYTE_W-1:0] ENTRY_LOCAL_CPU      = 8'd0;
  localparam logic [BYTE_W-1:0] ENTRY_IO_CTRL        = 8'd1;
  localparam logic [BYTE_W-1:0] ENTRY_ADDR_OVERRIDE  = 8'd5;

  // 'A' 'P' 'I' 'C'
  localparam logic [BYTE_W-1:0] SIG_BYTES [4] = '{8'h41, 8'h50, 8'h49, 8'h43};

  // walker status after the current beat
  typedef struct packed {
    logic                  bad_entry;
    logic [CNT_OUT_W-1:0]  cpu_count;
    logic [CNT_OUT_W-1:0]  io_count;
    logic [ADDR_W-1:0]     io_address;
    logic [ADDR_W-1:0]     io_base;
    logic                  override_hit;
    logic [ADDR_W-1:0]     override_address;
  } walk_stat_t;

endpackage

// ----- design/madt_entry_walk.sv -----
// variable-length entry walker: entry decode, tallies and first i/o controller capture
module madt_entry_walk #(
  parameter int unsigned COUNT_BITS = madt_pkg::DEF_COUNT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [madt_pkg::BYTE_W-1:0] byte_i,
  input  logic                        clear_i,
  output madt_pkg::walk_stat_t        stat_o
);
  import madt_pkg::*;

  logic [BYTE_W-1:0]     pos_q, pos_d, kind_q, kind_d, size_q, size_d;
  logic [ADDR_W-1:0]     f1_q, f1_d, f2_q, f2_d;
  logic [COUNT_BITS-1:0] cpu_q, cpu_d, io_q, io_d;
  logic [ADDR_W-1:0]     io_addr_q, io_addr_d, io_base_q, io_base_d;
  logic                  err_q, err_d;
  logic                  finish, ovr_hit;

  always_comb begin
    pos_d     = pos_q;
    kind_d    = kind_q;
    size_d    = size_q;
    f1_d      = f1_q;
    f2_d      = f2_q;
    cpu_d     = cpu_q;
    io_d      = io_q;
    io_addr_d = io_addr_q;
    io_base_d = io_base_q;
    err_d     = err_q;
    finish    = 1'b0;
    ovr_hit   = 1'b0;

    if (step_i && !err_q) begin
      if (pos_q == 8'd0) begin
        kind_d = byte_i;
        f1_d   = '0;
        f2_d   = '0;
        pos_d  = 8'd1;
      end else if (pos_q == 8'd1) begin
        size_d = byte_i;
        if (byte_i < 8'd2) begin
          err_d = 1'b1;
          pos_d = 8'd0;
        end else if (byte_i == 8'd2) begin
          finish = 1'b1;
          pos_d  = 8'd0;
        end else begin
          pos_d = 8'd2;
        end
      end else begin
        // bytes 4..7 and 8..11 of an entry are the two little-endian words
        if (pos_q[7:2] == 6'd1) begin
          f1_d[{pos_q[1:0], 3'b000} +: 8] = byte_i;
        end else if (pos_q[7:2] == 6'd2) begin
          f2_d[{pos_q[1:0], 3'b000} +: 8] = byte_i;
        end
        if ({1'b0, pos_q} + 9'd1 >= {1'b0, size_q}) begin
          finish = 1'b1;
          pos_d  = 8'd0;
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
    end

    if (finish) begin
      case (kind_d)
        ENTRY_LOCAL_CPU: begin
          if (f1_d[0] && !(&cpu_q)) cpu_d = cpu_q + 1'b1;
        end
        ENTRY_IO_CTRL: begin
          if (io_q == '0) begin
            io_addr_d = f1_d;
            io_base_d = f2_d;
          end
          if (!(&io_q)) io_d = io_q + 1'b1;
        end
        ENTRY_ADDR_OVERRIDE: begin
          ovr_hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat_o.bad_entry        = err_d;
    stat_o.cpu_count        = CNT_OUT_W'(cpu_d);
    stat_o.io_count         = CNT_OUT_W'(io_d);
    stat_o.io_address       = io_addr_d;
    stat_o.io_base          = io_base_d;
    stat_o.override_hit     = ovr_hit;
    stat_o.override_address = f1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      kind_q    <= '0;
      size_q    <= '0;
      f1_q      <= '0;
      f2_q      <= '0;
      cpu_q     <= '0;
      io_q      <= '0;
      io_addr_q <= '0;
      io_base_q <= '0;
      err_q     <= 1'b0;
    end else if (clear_i) begin
      pos_q     <= '0;
      kind_q    <= '0;
      size_q    <= '0;
      f1_q      <= '0;
      f2_q      <= '0;
      cpu_q     <= '0;
      io_q      <= '0;
      io_addr_q <= '0;
      io_base_q <= '0;
      err_q     <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      kind_q    <= kind_d;
      size_q    <= size_d;
      f1_q      <= f1_d;
      f2_q      <= f2_d;
      cpu_q     <= cpu_d;
      io_q      <= io_d;
      io_addr_q <= io_addr_d;
      io_base_q <= io_base_d;
      err_q     <= err_d;
    end
  end

endmodule

// ----- design/madt_stream_parser.sv -----
// top level of the streaming interrupt controller table parser
// Takes one table byte per cycle on the slave stream, from offset zero up, with tlast on
// the final byte. Every beat below the offset counter limit updates the parser state in
// the cycle it is accepted; the tlast beat loads one summary beat into the output
// register, which shows it on the master stream the next cycle, and the parser state
// returns to its reset values for the next table. Sustained rate is one byte per cycle,
// set by the single update pass between the state registers; s_axis_tready is low only
// while a summary beat sits in the output register and the master side holds tready low.
module madt_stream_parser #(
  parameter int unsigned OFFSET_BITS = madt_pkg::DEF_OFFSET_BITS,
  parameter int unsigned COUNT_BITS  = madt_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] table_byte
  input  logic                              s_axis_tlast,  // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] checksum_ok, [1] signature_ok, [2] malformed, [10:3] enabled_cpu_count,
  // [18:11] io_controller_count, [50:19] local_controller_address,
  // [82:51] io_controller_address, [114:83] io_interrupt_base, rest zero
  output logic [madt_pkg::RES_TDATA_W-1:0] m_axis_tdata
);
  import madt_pkg::*;

  localparam logic [LEN_W:0] OFF_MAX = (33'd1 << OFFSET_BITS) - 33'd1;

  logic [OFFSET_BITS-1:0] ofs_q, ofs_d, count;
  logic [LEN_W-1:0]       hlen_q, hlen_d, pos32;
  logic [BYTE_W-1:0]      sum_q, sum_d;
  logic                   sig_q, sig_d;
  logic [ADDR_W-1:0]      laddr_q, laddr_d;
  logic                   accept, last_beat, ofs_full, in_len, walk_step, bad;
  walk_stat_t             wstat;
  logic                   out_valid_q, out_valid_d;
  logic [RES_TDATA_W-1:0] out_data_q, out_data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_beat     = accept && s_axis_tlast;

  assign pos32    = LEN_W'(ofs_q);
  assign ofs_full = ({1'b0, pos32} == OFF_MAX);

  always_comb begin
    ofs_d   = ofs_q;
    hlen_d  = hlen_q;
    sum_d   = sum_q;
    sig_d   = sig_q;
    laddr_d = laddr_q;
    in_len  = 1'b0;
    if (accept && !ofs_full) begin
      if (pos32 < 32'd4 && s_axis_tdata != SIG_BYTES[pos32[1:0]]) sig_d = 1'b0;
      if (pos32[LEN_W-1:2] == 30'd1) hlen_d[{pos32[1:0], 3'b000} +: 8] = s_axis_tdata;
      in_len = (pos32 < HDR_FIXED_END) || (pos32 < hlen_d);
      if (in_len) begin
        sum_d = sum_q + s_axis_tdata;
        if (pos32[LEN_W-1:2] == LOCAL_ADDR_OFS[LEN_W-1:2]) begin
          laddr_d[{pos32[1:0], 3'b000} +: 8] = s_axis_tdata;
        end
      end
      ofs_d = ofs_q + 1'b1;
    end
    // override entries replace the header address
    if (wstat.override_hit) laddr_d = wstat.override_address;
  end

  assign walk_step = in_len && (pos32 >= ENTRY_START_OFS);

  madt_entry_walk #(
    .COUNT_BITS(COUNT_BITS)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (walk_step),
    .byte_i (s_axis_tdata),
    .clear_i(last_beat),
    .stat_o (wstat)
  );

  // bytes seen, pinned at the counter limit
  assign count = ofs_full ? ofs_q : ofs_q + 1'b1;
  assign bad   = wstat.bad_entry || ({1'b0, hlen_d} > OFF_MAX) ||
                 (LEN_W'(count) < HDR_FIXED_END) || (LEN_W'(count) < hlen_d);

  always_comb begin
    out_data_d = '0;
    out_data_d[RES_BITS-1:0] = {wstat.io_base, wstat.io_address, laddr_d,
                                wstat.io_count, wstat.cpu_count, bad,
                                sig_d && (LEN_W'(count) >= 32'd4),
                                (sum_d == '0)};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (last_beat) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q       <= '0;
      hlen_q      <= '0;
      sum_q       <= '0;
      sig_q       <= 1'b1;
      laddr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (last_beat) begin
        ofs_q   <= '0;
        hlen_q  <= '0;
        sum_q   <= '0;
        sig_q   <= 1'b1;
        laddr_q <= '0;
      end else begin
        ofs_q   <= ofs_d;
        hlen_q  <= hlen_d;
        sum_q   <= sum_d;
        sig_q   <= sig_d;
        laddr_q <= laddr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_beat) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- design/madt_checker.sv -----
// port-level checks of the table parser and their binding to the top level
module madt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [madt_pkg::RES_TDATA_W-1:0] m_axis_tdata
);
  import madt_pkg::*;

  // a held summary beat does not vanish
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("summary beat dropped while stalled");

  // input side only stalls behind a waiting summary beat
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // every last beat gives a summary beat next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("no summary after last beat");

  // the padding above the packed result stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[RES_TDATA_W-1:RES_BITS] == '0)
    else $error("nonzero padding in summary beat");

endmodule

bind madt_stream_parser madt_checker u_madt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
